// ===== hdl/assert_macros.svh =====
// assertion macros shared by the decoder rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define PCD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the cycle after the antecedent
`define PCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/pcd_pkg.sv =====
// types, constants and helper functions of the percent-escape decoder
// no dependencies; used by pcd_step and percent_escape_charset_decoder_core
`default_nettype none

package pcd_pkg;

    // string and output limits of the decoder
    localparam int unsigned MAX_STRING_LEN = 65536;
    localparam int unsigned MAX_OUT_BYTES  = 65536;

    localparam int unsigned LEFT_CLAMP = (MAX_STRING_LEN - 1 > 65535) ? 65535 :
                                         (MAX_STRING_LEN - 1);
    localparam int unsigned CAP_CLAMP  = (MAX_OUT_BYTES > 65535) ? 65535 : MAX_OUT_BYTES;
    localparam logic [15:0] LEFT_LIMIT = 16'(LEFT_CLAMP);
    localparam logic [15:0] CAP_LIMIT  = 16'(CAP_CLAMP);

    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    // configuration register indexes
    localparam logic CFG_GBK_SEL      = 1'b0;
    localparam logic CFG_OUT_CAPACITY = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_HEX1  = 3'd1,
        PH_HEX2  = 3'd2,
        PH_PCT   = 3'd3,
        PH_CHEX1 = 3'd4,
        PH_CHEX2 = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TRUNC     = 3'd1,
        ST_SHORT     = 3'd2,
        ST_NON_ASCII = 3'd3,
        ST_BAD_CODE  = 3'd4,
        ST_BAD_LEAD  = 3'd5,
        ST_FULL      = 3'd6
    } status_t;

    typedef struct packed {
        logic [15:0] count;
        status_t     status;
        logic        done;
        logic        has_byte;
        logic [7:0]  data;
    } pcd_result_t;

    typedef struct packed {
        phase_t      phase;
        logic [3:0]  high_nibble;
        logic [7:0]  first_gbk_byte;
        logic [2:0]  cont_left;
        logic [15:0] out_count;
        logic        discarding;
    } pcd_state_t;

    typedef struct packed {
        pcd_result_t res0;
        pcd_result_t res1;
        logic [1:0]  n_res;
        logic        fin;
        pcd_state_t  next;
    } pcd_step_t;

    localparam pcd_state_t STATE_CLEAR = '{
        phase: PH_IDLE, high_nibble: 4'd0, first_gbk_byte: 8'd0,
        cont_left: 3'd0, out_count: 16'd0, discarding: 1'b0
    };

    // bit 4 set means not a hex digit
    function automatic logic [4:0] hex_value(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            v = {1'b0, c[3:0]};
        end
        else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
        begin
            v = {1'b0, 4'(c[3:0] + 4'd9)};
        end
        return v;
    endfunction

    function automatic logic gbk_pair_ok(input logic [7:0] b0, input logic [7:0] b1);
        logic ok;
        ok = (b0 >= 8'hB0 && b0 <= 8'hF7 && b1 >= 8'hA1 && b1 <= 8'hFE)
          || (b0 >= 8'h81 && b0 <= 8'hA0 && b1 >= 8'h40 && b1 <= 8'hFE)
          || (b0 >= 8'hAA && b0 <= 8'hFE && b1 >= 8'h40 && b1 <= 8'hA0)
          || (b0 >= 8'hA1 && b0 <= 8'hA9 && b1 >= 8'hA1 && b1 <= 8'hFE)
          || (b0 >= 8'hA8 && b0 <= 8'hA9 && b1 >= 8'h40 && b1 <= 8'hA0);
        return ok;
    endfunction

    // {bad lead, number of continuation escapes}
    function automatic logic [3:0] utf8_follow(input logic [7:0] b);
        logic [3:0] r;
        if (!b[7])                      r = {1'b0, 3'd0};
        else if ((b & 8'hE0) == 8'hC0)  r = {1'b0, 3'd1};
        else if ((b & 8'hF0) == 8'hE0)  r = {1'b0, 3'd2};
        else if ((b & 8'hF8) == 8'hF0)  r = {1'b0, 3'd3};
        else if ((b & 8'hFC) == 8'hF8)  r = {1'b0, 3'd4};
        else if ((b & 8'hFE) == 8'hFC)  r = {1'b0, 3'd5};
        else                            r = {1'b1, 3'd0};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/pcd_step.sv =====
// per-character decode step: next decoder state and up to two result words
// depends on pcd_pkg
`default_nettype none

module pcd_step
    import pcd_pkg::*;
(
    input  wire pcd_state_t  st,
    input  wire logic [7:0]  in_char,
    input  wire logic [15:0] chars_left,
    input  wire logic        gbk_sel,
    input  wire logic [15:0] out_capacity,
    output pcd_step_t        step
);

    logic        last;
    logic        gbk;
    logic [15:0] left;
    logic [15:0] cap;
    logic [4:0]  hv;
    logic [7:0]  b;
    logic [3:0]  lead;
    logic [3:0]  need3;
    logic [15:0] room;

    logic [1:0]  e_cnt;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic        fin;
    status_t     fin_st;
    pcd_state_t  nx;

    assign last  = (chars_left == 16'd0);
    assign gbk   = gbk_sel;
    assign left  = (chars_left > LEFT_LIMIT) ? LEFT_LIMIT : chars_left;
    assign cap   = (out_capacity > CAP_LIMIT) ? CAP_LIMIT : out_capacity;
    assign hv    = hex_value(in_char);
    assign b     = {st.high_nibble, hv[3:0]};
    assign lead  = utf8_follow(b);
    assign need3 = {1'b0, lead[2:0]} + {lead[2:0], 1'b0};
    // the lead has been counted already, so this never goes negative
    assign room  = cap - 16'(st.out_count + 16'd1);

    // decision and next state
    always_comb
    begin
        e_cnt  = 2'd0;
        b0     = 8'd0;
        b1     = 8'd0;
        fin    = 1'b0;
        fin_st = ST_OK;
        nx     = st;

        if (st.discarding)
        begin
            if (last)
            begin
                nx = STATE_CLEAR;
            end
        end
        else
        begin
            unique case (st.phase)
                PH_IDLE:
                begin
                    if (in_char[7])
                    begin
                        fin = 1'b1; fin_st = ST_NON_ASCII;
                    end
                    else if (in_char == CHAR_PERCENT)
                    begin
                        if (left < 16'd2)
                        begin
                            fin = 1'b1; fin_st = ST_SHORT;
                        end
                        else
                        begin
                            nx.phase = PH_HEX1;
                        end
                    end
                    else if (st.out_count >= cap)
                    begin
                        fin = 1'b1; fin_st = gbk ? ST_FULL : ST_TRUNC;
                    end
                    else
                    begin
                        e_cnt = 2'd1; b0 = in_char;
                    end
                end
                PH_HEX1, PH_CHEX1:
                begin
                    if (hv[4])
                    begin
                        fin = 1'b1; fin_st = ST_BAD_CODE;
                    end
                    else
                    begin
                        nx.high_nibble = hv[3:0];
                        nx.phase = (st.phase == PH_HEX1) ? PH_HEX2 : PH_CHEX2;
                    end
                end
                PH_HEX2:
                begin
                    if (hv[4])
                    begin
                        fin = 1'b1; fin_st = ST_BAD_CODE;
                    end
                    else if (gbk)
                    begin
                        if (b[7])
                        begin
                            if (left < 16'd3)
                            begin
                                fin = 1'b1; fin_st = ST_SHORT;
                            end
                            else
                            begin
                                nx.first_gbk_byte = b;
                                nx.cont_left = 3'd1;
                                nx.phase = PH_PCT;
                            end
                        end
                        else if (st.out_count >= cap)
                        begin
                            fin = 1'b1; fin_st = ST_FULL;
                        end
                        else
                        begin
                            e_cnt = 2'd1; b0 = b;
                            nx.phase = PH_IDLE;
                        end
                    end
                    else if (lead[3])
                    begin
                        fin = 1'b1; fin_st = ST_BAD_LEAD;
                    end
                    else if (st.out_count >= cap)
                    begin
                        fin = 1'b1; fin_st = ST_TRUNC;
                    end
                    else
                    begin
                        // the lead goes out even if its continuations fail the checks
                        e_cnt = 2'd1; b0 = b;
                        nx.phase = PH_IDLE;
                        if (lead[2:0] != 3'd0)
                        begin
                            if (left < {12'd0, need3})
                            begin
                                fin = 1'b1; fin_st = ST_SHORT;
                            end
                            else if ({13'd0, lead[2:0]} > room)
                            begin
                                fin = 1'b1; fin_st = ST_SHORT;
                            end
                            else
                            begin
                                nx.cont_left = lead[2:0];
                                nx.phase = PH_PCT;
                            end
                        end
                    end
                end
                PH_PCT:
                begin
                    if (in_char != CHAR_PERCENT)
                    begin
                        fin = 1'b1; fin_st = ST_BAD_CODE;
                    end
                    else
                    begin
                        nx.phase = PH_CHEX1;
                    end
                end
                default:
                begin
                    if (hv[4])
                    begin
                        fin = 1'b1; fin_st = ST_BAD_CODE;
                    end
                    else if (gbk)
                    begin
                        if (!gbk_pair_ok(st.first_gbk_byte, b))
                        begin
                            fin = 1'b1; fin_st = ST_BAD_CODE;
                        end
                        else if (({1'b0, st.out_count} + 17'd2) >= {1'b0, cap})
                        begin
                            fin = 1'b1; fin_st = ST_FULL;
                        end
                        else
                        begin
                            e_cnt = 2'd2; b0 = st.first_gbk_byte; b1 = b;
                            nx.cont_left = 3'd0;
                            nx.phase = PH_IDLE;
                        end
                    end
                    else if (st.out_count >= cap)
                    begin
                        fin = 1'b1; fin_st = ST_SHORT;
                    end
                    else
                    begin
                        e_cnt = 2'd1; b0 = b;
                        nx.cont_left = st.cont_left - 3'd1;
                        nx.phase = (st.cont_left == 3'd1) ? PH_IDLE : PH_PCT;
                    end
                end
            endcase

            // end of string closes the run, short if an escape is still open
            if (!fin && last)
            begin
                fin = 1'b1;
                fin_st = (nx.phase == PH_IDLE) ? ST_OK : ST_SHORT;
            end

            if (fin)
            begin
                nx = STATE_CLEAR;
                nx.discarding = !last;
            end
            else
            begin
                nx.out_count = st.out_count + {14'd0, e_cnt};
            end
        end
    end

    // result words
    always_comb
    begin
        step.next = nx;
        step.fin  = fin && !st.discarding;

        step.res0.data     = (e_cnt != 2'd0) ? b0 : 8'd0;
        step.res0.has_byte = (e_cnt != 2'd0);
        step.res0.count    = st.out_count + ((e_cnt != 2'd0) ? 16'd1 : 16'd0);
        step.res0.done     = fin && (e_cnt != 2'd2);
        step.res0.status   = (fin && (e_cnt != 2'd2)) ? fin_st : ST_OK;

        step.res1.data     = b1;
        step.res1.has_byte = 1'b1;
        step.res1.count    = st.out_count + 16'd2;
        step.res1.done     = fin && (e_cnt == 2'd2);
        step.res1.status   = (fin && (e_cnt == 2'd2)) ? fin_st : ST_OK;

        if (st.discarding)
        begin
            step.n_res = 2'd0;
        end
        else if (e_cnt != 2'd0)
        begin
            step.n_res = e_cnt;
        end
        else
        begin
            step.n_res = {1'b0, fin};
        end
    end

endmodule

`default_nettype wire

// ===== hdl/percent_escape_charset_decoder_core.sv =====
// top level of the percent-escape decoder with utf-8 / gbk checking
// depends on pcd_pkg, pcd_step and assert_macros.svh
//
// usage
//  - input stream s_*: one word per character, in_char and the count of
//    characters still to come (0 on the last one of a string)
//  - output stream m_*: decoded bytes (m_tuser high) and one final word per
//    string with m_tlast high, carrying status and decoded count
//  - cfg_we/cfg_index/cfg_wdata write the charset select (0, 1 for gbk) or
//    out_capacity (1); writes are registered, and the user must make writes
//    only while the block is idle; the block itself does not enforce it
//  - the result words of a taken character are written into the result queue,
//    whose head word drives m_*
//  - throughput: one character per cycle while s_tready is high; a character
//    yields up to two result words, the output side drains one word per cycle
//    while m_tready is high, so a gbk pair occupies the output for two words
//  - a four-word result queue sits between the decode step and m_*;
//    s_tready is high while at most two words wait in the queue, so a
//    stalled receiver drops s_tready once three or four words are waiting
//  - reset clears the decoder state, empties the queue and selects utf-8
//    with out_capacity 65535
//  - after an error the rest of the string is consumed with no results
`default_nettype none

`include "assert_macros.svh"

module percent_escape_charset_decoder_core
    import pcd_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input words
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // in_char[7:0], chars_left[23:8]
    // result words
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // out_byte[7:0], status[10:8], decoded_count[26:11]
    output logic             m_tlast,   // done_res
    output logic             m_tuser,   // has_byte
    // configuration writes
    input  wire logic        cfg_we,
    input  wire logic        cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = $clog2(QDEPTH);

    logic             gbk_sel_reg;
    logic [15:0]      out_capacity_reg;

    pcd_state_t       state_reg;
    pcd_state_t       state_next;

    // result queue, payload only
    pcd_result_t      queue_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   wr_ptr_next;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW-1:0]   rd_ptr_next;
    logic [QAW:0]     fill_reg;
    logic [QAW:0]     fill_next;

    pcd_step_t        step;
    pcd_result_t      head;
    logic             s_accept;
    logic             m_accept;
    logic [1:0]       push_n;

    pcd_step u_step (
        .st           (state_reg),
        .in_char      (s_tdata[7:0]),
        .chars_left   (s_tdata[23:8]),
        .gbk_sel      (gbk_sel_reg),
        .out_capacity (out_capacity_reg),
        .step         (step)
    );

    // handshakes; room for two words keeps a gbk pair from overrunning
    assign s_tready = (fill_reg <= (QAW+1)'(QDEPTH - 2));
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = (fill_reg != '0);
    assign m_accept = m_tvalid && m_tready;
    assign push_n   = s_accept ? step.n_res : 2'd0;

    assign head    = queue_reg[rd_ptr_reg];
    assign m_tdata = {5'd0, head.count, head.status, head.data};
    assign m_tlast = head.done;
    assign m_tuser = head.has_byte;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gbk_sel_reg      <= 1'b0;
            out_capacity_reg <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GBK_SEL:      gbk_sel_reg      <= cfg_wdata[0];
                CFG_OUT_CAPACITY: out_capacity_reg <= cfg_wdata;
                default:          gbk_sel_reg      <= gbk_sel_reg;
            endcase
        end
    end

    // decoder state advances only on a taken character
    assign state_next = s_accept ? step.next : state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= STATE_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QAW'(push_n);
        rd_ptr_next = rd_ptr_reg + QAW'(m_accept);
        fill_next   = fill_reg + (QAW+1)'(push_n) - (QAW+1)'(m_accept);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_n != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= step.res0;
        end
        if (push_n == 2'd2)
        begin
            queue_reg[QAW'(wr_ptr_reg + QAW'(1))] <= step.res1;
        end
    end

    // checks
    `PCD_ASSERT_NOW(a_no_overflow, s_accept,
        (fill_reg + (QAW+1)'(push_n)) <= (QAW+1)'(QDEPTH), "result queue overflow")
    `PCD_ASSERT_NOW(a_quiet_discard, s_accept && state_reg.discarding,
        push_n == 2'd0, "result produced while dropping a string")
    `PCD_ASSERT_NEXT(a_fin_clears, s_accept && step.fin,
        state_reg.out_count == 16'd0 && state_reg.phase == PH_IDLE,
        "string state not cleared after final word")

endmodule

`default_nettype wire
